[hdl/sstq_pkg.sv]
// Shared types, sizes and helpers for the sorted sleep timer queue.
// No dependencies; used by sstq_ram users and the top level.
`timescale 1ns / 1ps

package sstq_pkg;

	// Queue sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int MAX_RESULTS = 16;
	localparam int TIME_W      = 32;

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [NRES_W-1:0]  nres_t;
	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [TIME_W-1:0]  time_t;

	// Command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	// One queue entry as stored in memory
	typedef struct packed {
		time_t wake;
		id_t   id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Request and result payloads
	typedef struct packed {
		logic        cmd;
		logic [7:0]  sleeper_id;
		logic [15:0] duration;
	} req_t;

	typedef struct packed {
		logic       woken_valid;
		logic [7:0] woken_id;
		logic       full_res;
		logic       last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_POP_RD,
		ST_POP_CHK
	} state_t;

	// Physical slot of a logical queue position in the circular buffer
	function automatic idx_t phys(input idx_t head, input cnt_t ofs);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, ofs};
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH))
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		return idx_t'(sum);
	endfunction

endpackage

[hdl/sstq_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sstq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/sorted_sleep_timer_queue.sv]
// Sorted sleep timer queue: tick counter plus wake-time ordered sleeper list.
// Depends on sstq_pkg and sstq_ram.
`timescale 1ns / 1ps

// Usage:
//  A request is taken when start is high and busy is low. cmd selects a timer
//  tick or a sleep request (sleeper_id, duration). Each result appears on res
//  for one cycle with strobe high; the receiver always takes it. The last
//  result of a request has last set.
//  Sleep: one result, full_res set when the queue held its full depth; then
//  the result follows in the cycle after accept. Otherwise the entry is placed
//  by a backward pass from the tail that moves every entry waking no earlier
//  down one slot: each is read, then written one slot nearer the tail. The
//  pass ends when it reaches the head or a compare finds an earlier wake.
//  Tick: the count advances and the head is checked against it; each woken
//  sleeper is popped and its result held back until the next wake is read,
//  and the tick ends when an entry is left that is not due or the queue runs
//  empty. An empty tick gives one result with only last set. The single read
//  port of the entry memory sets the rate.
//  Entries live in a circular buffer, so a pop only moves the head pointer.
//  Reset clears the tick count, the fill count and the head pointer; the
//  memory is not cleared since only filled slots are ever read.

module sorted_sleep_timer_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sstq_pkg::req_t  req,
	output logic            strobe,
	output sstq_pkg::res_t  res
);

	sstq_pkg::state_t state_q, state_d;
	sstq_pkg::time_t  time_q, time_d;
	sstq_pkg::idx_t   head_q, head_d;
	sstq_pkg::cnt_t   count_q, count_d;
	sstq_pkg::cnt_t   idx_q, idx_d;
	sstq_pkg::time_t  key_q, key_d;
	sstq_pkg::entry_t new_q, new_d;
	sstq_pkg::id_t    pend_id_q, pend_id_d;
	logic             pend_valid_q, pend_valid_d;
	sstq_pkg::nres_t  nres_q, nres_d;
	sstq_pkg::res_t   res_q, res_d;
	logic             strobe_q, strobe_d;

	logic             we;
	sstq_pkg::idx_t   waddr, raddr;
	sstq_pkg::entry_t wdata, rdata;
	logic [15:0]      dur;

	sstq_ram #(
		.DEPTH (sstq_pkg::QUEUE_DEPTH),
		.WIDTH (sstq_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy   = (state_q != sstq_pkg::ST_IDLE);
	assign strobe = strobe_q;
	assign res    = res_q;
	assign dur    = (req.duration == 16'd0) ? 16'd1 : req.duration;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sstq_pkg::ST_IDLE;
			time_q       <= '0;
			head_q       <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			nres_q       <= '0;
			strobe_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			time_q       <= time_d;
			head_q       <= head_d;
			count_q      <= count_d;
			pend_valid_q <= pend_valid_d;
			nres_q       <= nres_d;
			strobe_q     <= strobe_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		key_q     <= key_d;
		new_q     <= new_d;
		pend_id_q <= pend_id_d;
		res_q     <= res_d;
	end

	// Sequencer: next state, memory access and result
	always_comb begin
		state_d      = state_q;
		time_d       = time_q;
		head_d       = head_q;
		count_d      = count_q;
		idx_d        = idx_q;
		key_d        = key_q;
		new_d        = new_q;
		pend_id_d    = pend_id_q;
		pend_valid_d = pend_valid_q;
		nres_d       = nres_q;
		res_d        = res_q;
		strobe_d     = 1'b0;
		we           = 1'b0;
		waddr        = '0;
		wdata        = new_q;
		raddr        = '0;

		case (state_q)
			sstq_pkg::ST_IDLE: begin
				if (start) begin
					if (req.cmd == sstq_pkg::CMD_SLEEP) begin
						if (count_q >= sstq_pkg::CNT_W'(sstq_pkg::QUEUE_DEPTH)) begin
							res_d    = '{woken_valid: 1'b0, woken_id: 8'd0,
							             full_res: 1'b1, last: 1'b1};
							strobe_d = 1'b1;
						end else begin
							key_d    = sstq_pkg::TIME_W'(dur);
							new_d.wake = time_q + sstq_pkg::TIME_W'(dur);
							new_d.id   = sstq_pkg::id_t'(req.sleeper_id);
							idx_d    = count_q;
							state_d  = sstq_pkg::ST_INS_RD;
						end
					end else begin
						time_d       = time_q + 1'b1;
						pend_valid_d = 1'b0;
						nres_d       = '0;
						state_d      = sstq_pkg::ST_POP_RD;
					end
				end
			end

			// Insert: fetch the entry ahead of the hole, or drop in at the head
			sstq_pkg::ST_INS_RD: begin
				if (idx_q == '0) begin
					we       = 1'b1;
					waddr    = sstq_pkg::phys(head_q, '0);
					wdata    = new_q;
					count_d  = count_q + 1'b1;
					res_d    = '{woken_valid: 1'b0, woken_id: 8'd0,
					             full_res: 1'b0, last: 1'b1};
					strobe_d = 1'b1;
					state_d  = sstq_pkg::ST_IDLE;
				end else begin
					raddr   = sstq_pkg::phys(head_q, idx_q - 1'b1);
					state_d = sstq_pkg::ST_INS_CHK;
				end
			end

			// Insert: move the entry down if it wakes no earlier, else place the new one
			sstq_pkg::ST_INS_CHK: begin
				we    = 1'b1;
				waddr = sstq_pkg::phys(head_q, idx_q);
				if ((rdata.wake - time_q) >= key_q) begin
					wdata   = rdata;
					idx_d   = idx_q - 1'b1;
					state_d = sstq_pkg::ST_INS_RD;
				end else begin
					wdata    = new_q;
					count_d  = count_q + 1'b1;
					res_d    = '{woken_valid: 1'b0, woken_id: 8'd0,
					             full_res: 1'b0, last: 1'b1};
					strobe_d = 1'b1;
					state_d  = sstq_pkg::ST_IDLE;
				end
			end

			// Pop: read the head, or close out the tick when empty
			sstq_pkg::ST_POP_RD: begin
				if (count_q == '0) begin
					res_d = '{woken_valid: pend_valid_q,
					          woken_id: pend_valid_q ? 8'(pend_id_q) : 8'd0,
					          full_res: 1'b0, last: 1'b1};
					strobe_d = 1'b1;
					state_d  = sstq_pkg::ST_IDLE;
				end else begin
					raddr   = sstq_pkg::phys(head_q, '0);
					state_d = sstq_pkg::ST_POP_CHK;
				end
			end

			// Pop: one held-back result goes out once the next wake is known
			sstq_pkg::ST_POP_CHK: begin
				if (rdata.wake == time_q) begin
					head_d  = sstq_pkg::phys(head_q, sstq_pkg::CNT_W'(1));
					count_d = count_q - 1'b1;
					if (nres_q < sstq_pkg::NRES_W'(sstq_pkg::MAX_RESULTS)) begin
						if (pend_valid_q) begin
							res_d = '{woken_valid: 1'b1, woken_id: 8'(pend_id_q),
							          full_res: 1'b0, last: 1'b0};
							strobe_d = 1'b1;
						end
						pend_id_d    = rdata.id;
						pend_valid_d = 1'b1;
						nres_d       = nres_q + 1'b1;
					end
					state_d = sstq_pkg::ST_POP_RD;
				end else begin
					res_d = '{woken_valid: pend_valid_q,
					          woken_id: pend_valid_q ? 8'(pend_id_q) : 8'd0,
					          full_res: 1'b0, last: 1'b1};
					strobe_d = 1'b1;
					state_d  = sstq_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = sstq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
